/* design/bdc_pkg.sv */
`timescale 1ns / 1ps

package bdc_pkg;

  // fixed field widths
  localparam int unsigned RawW    = 10;
  localparam int unsigned NowW    = 32;
  localparam int unsigned ThrW    = 12;
  localparam int unsigned SelW    = 2;
  localparam int unsigned DrvW    = 3;
  localparam int unsigned SpeedW  = 7;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  // button positions in the raw press vector
  localparam int unsigned BtnFwd    = 0;
  localparam int unsigned BtnBack   = 1;
  localparam int unsigned BtnLeft   = 2;
  localparam int unsigned BtnRight  = 3;
  localparam int unsigned BtnLiftUp = 4;
  localparam int unsigned BtnLiftDn = 5;
  localparam int unsigned BtnCastUp = 6;
  localparam int unsigned BtnCastDn = 7;
  localparam int unsigned BtnEmerg  = 8;
  localparam int unsigned BtnRun    = 9;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DELAY  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE = 2'd1;

  localparam logic [DelayW-1:0] DELAY_RESET = 16'd50;

  // selector codes
  localparam logic [SelW-1:0] SEL_NONE   = 2'd0;
  localparam logic [SelW-1:0] SEL_FIRST  = 2'd1;
  localparam logic [SelW-1:0] SEL_SECOND = 2'd2;

  // drive command codes
  localparam logic [DrvW-1:0] DRV_NONE  = 3'd0;
  localparam logic [DrvW-1:0] DRV_ESTOP = 3'd1;
  localparam logic [DrvW-1:0] DRV_STOP  = 3'd2;
  localparam logic [DrvW-1:0] DRV_FWD   = 3'd3;
  localparam logic [DrvW-1:0] DRV_BACK  = 3'd4;
  localparam logic [DrvW-1:0] DRV_LEFT  = 3'd5;
  localparam logic [DrvW-1:0] DRV_RIGHT = 3'd6;

  // lift and cast command codes
  localparam logic [CmdW-1:0] ACT_NONE = 2'd0;
  localparam logic [CmdW-1:0] ACT_UP   = 2'd1;
  localparam logic [CmdW-1:0] ACT_DOWN = 2'd2;
  localparam logic [CmdW-1:0] ACT_STOP = 2'd3;

  // throttle scaling
  localparam logic [SpeedW-1:0] TURN_SPEED  = 7'd30;
  localparam logic [SpeedW-1:0] SPEED_SCALE = 7'd100;
  localparam logic [ThrW:0]     THR_FULL    = 13'd4095;

  // command unit result
  typedef struct packed {
    logic [SelW-1:0]   dir_sel;
    logic [SelW-1:0]   lift_sel;
    logic [SelW-1:0]   cast_sel;
    logic [DrvW-1:0]   drive_cmd;
    logic [SpeedW-1:0] drive_speed;
    logic [CmdW-1:0]   lift_cmd;
    logic [CmdW-1:0]   cast_cmd;
  } cmd_t;

endpackage

/* design/bdc_scan_if.sv */
`timescale 1ns / 1ps

interface bdc_scan_if
  import bdc_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressed;
  logic [NowW-1:0] now_ms;
  logic [ThrW-1:0] throttle_sample;

  modport source (output valid, raw_pressed, now_ms, throttle_sample, input ready);
  modport sink (input valid, raw_pressed, now_ms, throttle_sample, output ready);
endinterface

/* design/bdc_result_if.sv */
`timescale 1ns / 1ps

interface bdc_result_if
  import bdc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [RawW-1:0]   pressed_mask;
  logic [RawW-1:0]   just_pressed_mask;
  logic [RawW-1:0]   just_released_mask;
  logic [SelW-1:0]   direction_select;
  logic [SelW-1:0]   lift_select;
  logic [SelW-1:0]   cast_select;
  logic [DrvW-1:0]   drive_command;
  logic [SpeedW-1:0] drive_speed;
  logic [CmdW-1:0]   lift_command;
  logic [CmdW-1:0]   cast_command;

  modport source (
    output valid, pressed_mask, just_pressed_mask, just_released_mask, direction_select,
           lift_select, cast_select, drive_command, drive_speed, lift_command,
           cast_command,
    input  ready
  );
  modport sink (
    input  valid, pressed_mask, just_pressed_mask, just_released_mask, direction_select,
           lift_select, cast_select, drive_command, drive_speed, lift_command,
           cast_command,
    output ready
  );
endinterface

/* design/bdc_cfg_if.sv */
`timescale 1ns / 1ps

interface bdc_cfg_if
  import bdc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

/* design/bdc_command.sv */
`timescale 1ns / 1ps

module bdc_command
  import bdc_pkg::*;
(
  input  logic [RawW-1:0] pressed_i,
  input  logic [RawW-1:0] just_pressed_i,
  input  logic [RawW-1:0] raw_i,
  input  logic [ThrW-1:0] thr_i,
  input  logic            enable_i,
  output cmd_t            cmd_o
);

  logic [ThrW+SpeedW-1:0] prod;
  logic [SpeedW-1:0]      q_est;
  logic [ThrW:0]          rem_est;
  logic [SpeedW-1:0]      speed;
  logic [SelW-1:0]        dir_sel;
  logic [SelW-1:0]        lift_sel;
  logic [SelW-1:0]        cast_sel;

  // speed = thr*100/4095: floor by 4096, then one correction step
  assign prod    = (ThrW+SpeedW)'(thr_i) * (ThrW+SpeedW)'(SPEED_SCALE);
  assign q_est   = prod[ThrW+SpeedW-1:ThrW];
  assign rem_est = {1'b0, prod[ThrW-1:0]} + (ThrW+1)'(q_est);
  assign speed   = (rem_est >= THR_FULL) ? q_est + SpeedW'(1) : q_est;

  // raw selectors, first button wins
  always_comb begin
    priority if (raw_i[BtnFwd]) dir_sel = SEL_FIRST;
    else if (raw_i[BtnBack])    dir_sel = SEL_SECOND;
    else                        dir_sel = SEL_NONE;
    priority if (raw_i[BtnLiftUp]) lift_sel = SEL_FIRST;
    else if (raw_i[BtnLiftDn])     lift_sel = SEL_SECOND;
    else                           lift_sel = SEL_NONE;
    priority if (raw_i[BtnCastUp]) cast_sel = SEL_FIRST;
    else if (raw_i[BtnCastDn])     cast_sel = SEL_SECOND;
    else                           cast_sel = SEL_NONE;
  end

  // command decision with enable, emergency and run gating
  always_comb begin
    cmd_o             = '0;
    cmd_o.dir_sel     = dir_sel;
    cmd_o.lift_sel    = lift_sel;
    cmd_o.cast_sel    = cast_sel;
    cmd_o.drive_cmd   = DRV_NONE;
    cmd_o.drive_speed = '0;
    cmd_o.lift_cmd    = ACT_NONE;
    cmd_o.cast_cmd    = ACT_NONE;
    if (enable_i) begin
      priority if (just_pressed_i[BtnEmerg]) begin
        cmd_o.drive_cmd = DRV_ESTOP;
      end else if (!pressed_i[BtnRun]) begin
        cmd_o.drive_cmd = DRV_STOP;
      end else begin
        priority if (dir_sel == SEL_FIRST) begin
          cmd_o.drive_cmd   = DRV_FWD;
          cmd_o.drive_speed = speed;
        end else if (dir_sel == SEL_SECOND) begin
          cmd_o.drive_cmd   = DRV_BACK;
          cmd_o.drive_speed = speed;
        end else if (pressed_i[BtnLeft]) begin
          cmd_o.drive_cmd   = DRV_LEFT;
          cmd_o.drive_speed = TURN_SPEED;
        end else if (pressed_i[BtnRight]) begin
          cmd_o.drive_cmd   = DRV_RIGHT;
          cmd_o.drive_speed = TURN_SPEED;
        end else begin
          cmd_o.drive_cmd = DRV_STOP;
        end
        priority if (lift_sel == SEL_FIRST) cmd_o.lift_cmd = ACT_UP;
        else if (lift_sel == SEL_SECOND)     cmd_o.lift_cmd = ACT_DOWN;
        else                                 cmd_o.lift_cmd = ACT_STOP;
        priority if (cast_sel == SEL_FIRST) cmd_o.cast_cmd = ACT_UP;
        else if (cast_sel == SEL_SECOND)     cmd_o.cast_cmd = ACT_DOWN;
        else                                 cmd_o.cast_cmd = ACT_STOP;
      end
    end
  end

endmodule

/* design/button_debounce_drive_commander.sv */
`timescale 1ns / 1ps
// Debounced button panel that turns each scan into a vehicle command.
// scan_i (sink): one transfer per scan with raw press bits, millisecond time and
//   throttle sample. result_o (source): one transfer per scan with the debounced,
//   just-pressed and just-released masks, raw selectors and drive/lift/cast commands.
// cfg_i (sink): register writes, index 0 debounce delay, index 1 command enable;
//   always ready, to be written only while no scan is in flight.
// Per-button level, prior level and last change time live in one memory of
//   BUTTON_COUNT entries read one button per cycle through a registered read port,
//   each entry updated and written back on a change in the cycle after its read.
// An accepted scan is swept through the button memory and its result then loaded
//   into the output register; the single read port must finish sweeping the memory
//   before the next scan is taken, so scans do not overlap.
// A new scan is taken in the same cycle as the previous result is loaded, so a
//   waiting result never blocks the next scan's sweep; when the receiver stalls,
//   the finished sweep holds until the output register frees.
// Reset clears all per-button state through per-entry valid bits (no clearing
//   pass), sets the delay to 50 ms and disables commands.

module button_debounce_drive_commander
  import bdc_pkg::*;
#(
  parameter int unsigned BUTTON_COUNT = 10,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdc_scan_if.sink    scan_i,
  bdc_result_if.source result_o,
  bdc_cfg_if.sink     cfg_i
);

  localparam int unsigned AW = $clog2(BUTTON_COUNT);
  localparam int unsigned CW = $clog2(BUTTON_COUNT + 1);
  localparam int unsigned EW = TIME_BITS + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [DelayW-1:0]       delay_q;
  logic                    enable_q;
  logic [BUTTON_COUNT-1:0] raw_q;
  logic [TIME_BITS-1:0]    now_q;
  logic [ThrW-1:0]         thr_q;
  logic [CW-1:0]           rd_cnt_q, rd_cnt_d;
  logic                    rd_pend_q, rd_pend_d;
  logic [AW-1:0]           rd_idx_q;
  logic                    rd_en;
  logic [EW-1:0]           mem_q [BUTTON_COUNT];
  logic [EW-1:0]           rd_data_q;
  logic                    rd_vld_q;
  logic [BUTTON_COUNT-1:0] vld_q;
  logic [BUTTON_COUNT-1:0] pm_q, pm_d;
  logic [BUTTON_COUNT-1:0] jp_q, jp_d;
  logic [BUTTON_COUNT-1:0] jr_q, jr_d;
  logic                    out_valid_q;
  logic [RawW-1:0]         out_pm_q, out_jp_q, out_jr_q;
  cmd_t                    out_cmd_q;
  cmd_t                    cmd;
  logic                    out_free;
  logic                    scan_xfer;
  logic                    out_load;

  // entry fields
  logic [EW-1:0]           entry;
  logic                    lvl, pri, cur;
  logic [TIME_BITS-1:0]    last_t, elapsed;
  logic                    take;
  logic                    new_lvl, new_pri;
  logic                    wr_en;

  // handshakes
  assign out_free    = !out_valid_q || result_o.ready;
  assign out_load    = (state_q == ST_DONE) && out_free;
  assign scan_i.ready = (state_q == ST_IDLE) || out_load;
  assign scan_xfer   = scan_i.valid && scan_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DELAY_RESET;
      enable_q <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CFG_DELAY:  delay_q  <= cfg_i.wdata;
        CFG_ENABLE: enable_q <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // scan capture
  always_ff @(posedge clk_i) begin
    if (scan_xfer) begin
      raw_q <= BUTTON_COUNT'(scan_i.raw_pressed);
      now_q <= TIME_BITS'(scan_i.now_ms);
      thr_q <= scan_i.throttle_sample;
    end
  end

  // current entry, unwritten entries read as reset state
  assign entry   = rd_vld_q ? rd_data_q : '0;
  assign lvl     = entry[EW-1];
  assign pri     = entry[EW-2];
  assign last_t  = entry[TIME_BITS-1:0];
  assign cur     = raw_q[rd_idx_q];
  assign elapsed = now_q - last_t;
  assign take    = (cur != lvl) && (elapsed > TIME_BITS'(delay_q));
  assign new_lvl = take ? cur : lvl;
  assign new_pri = take ? lvl : pri;
  assign wr_en   = (state_q == ST_SCAN) && rd_pend_q && take;

  // sweep sequencer and mask accumulation
  always_comb begin
    state_d   = state_q;
    rd_cnt_d  = rd_cnt_q;
    rd_pend_d = 1'b0;
    rd_en     = 1'b0;
    pm_d      = pm_q;
    jp_d      = jp_q;
    jr_d      = jr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (scan_xfer) begin
          state_d  = ST_SCAN;
          rd_cnt_d = '0;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_q < CW'(BUTTON_COUNT)) begin
          rd_en     = 1'b1;
          rd_pend_d = 1'b1;
          rd_cnt_d  = rd_cnt_q + CW'(1);
        end
        if (rd_pend_q) begin
          pm_d[rd_idx_q] = new_lvl;
          jp_d[rd_idx_q] = new_lvl && !new_pri;
          jr_d[rd_idx_q] = !new_lvl && new_pri;
          if (rd_idx_q == AW'(BUTTON_COUNT - 1)) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = scan_xfer ? ST_SCAN : ST_IDLE;
          rd_cnt_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
      vld_q     <= '0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rd_pend_q <= rd_pend_d;
      if (wr_en) begin
        vld_q[rd_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pm_q <= pm_d;
    jp_q <= jp_d;
    jr_q <= jr_d;
  end

  // button state memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_cnt_q[AW-1:0]];
      rd_vld_q  <= vld_q[rd_cnt_q[AW-1:0]];
      rd_idx_q  <= rd_cnt_q[AW-1:0];
    end
    if (wr_en) begin
      mem_q[rd_idx_q] <= {new_lvl, new_pri, now_q};
    end
  end

  bdc_command u_command (
    .pressed_i      (pm_q[RawW-1:0]),
    .just_pressed_i (jp_q[RawW-1:0]),
    .raw_i          (raw_q[RawW-1:0]),
    .thr_i          (thr_q),
    .enable_i       (enable_q),
    .cmd_o          (cmd)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pm_q  <= pm_q[RawW-1:0];
      out_jp_q  <= jp_q[RawW-1:0];
      out_jr_q  <= jr_q[RawW-1:0];
      out_cmd_q <= cmd;
    end
  end

  assign result_o.valid              = out_valid_q;
  assign result_o.pressed_mask       = out_pm_q;
  assign result_o.just_pressed_mask  = out_jp_q;
  assign result_o.just_released_mask = out_jr_q;
  assign result_o.direction_select   = out_cmd_q.dir_sel;
  assign result_o.lift_select        = out_cmd_q.lift_sel;
  assign result_o.cast_select        = out_cmd_q.cast_sel;
  assign result_o.drive_command      = out_cmd_q.drive_cmd;
  assign result_o.drive_speed        = out_cmd_q.drive_speed;
  assign result_o.lift_command       = out_cmd_q.lift_cmd;
  assign result_o.cast_command       = out_cmd_q.cast_cmd;

endmodule
